// ----- rtl/core/pip_pkg.sv -----
// shared types and constants for the point-in-polygon block
// no dependencies; used by every module of the block
`default_nettype none

package pip_pkg;

    // default sizes for the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 32;

    // a polygon needs at least this many vertices to enclose anything
    localparam int MIN_VERTICES = 3;

    // request commands
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    // status from the edge unit back to the controller
    typedef struct packed {
        logic busy;
        logic hit_vld;
    } edge_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_in_polygon_test.sv -----
// point-in-polygon test, even-odd crossing rule, top level and controller
// a query walks the stored vertices through the edge unit and is answered from S_DONE;
// no new request is taken until its result is loaded; under three vertices it answers
// outside without a walk; a stalled result holds a finished query; clear and append keep the block ready
// the edge walk reads one vertex a cycle from the vertex store read port
// reset (async, active low) empties the polygon and the overflow flag
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic               inside_res,
    output logic               vertex_overflow
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CW     = COORD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // polygon bookkeeping
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    // walk control
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             rd_vld_reg;
    logic             rd_first_reg;
    logic             acc_reg, acc_next;

    // result register
    logic             rsp_valid_reg, rsp_valid_next;
    logic             inside_reg;
    logic             rsp_ovf_reg;
    logic             rsp_load;

    // query point and previous vertex
    logic signed [CW-1:0] qx_reg, qy_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;

    // coordinates reduced to the internal width
    logic signed [CW-1:0] cx, cy;

    logic                     req_acc;
    logic                     wr_en;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         rd_addr_full;
    logic [2*CW-1:0]          rd_data;
    logic signed [CW-1:0]     vx, vy;
    logic                     edge_vld;
    pip_pkg::edge_stat_t      edge_stat;

    assign cx = CW'(coord_x);
    assign cy = CW'(coord_y);

    assign req_ready = (state_reg == S_IDLE);
    assign req_acc   = req_valid & req_ready;

    // vertex store: y in the upper half, x in the lower half
    assign vx = rd_data[CW-1:0];
    assign vy = rd_data[2*CW-1:CW];

    // first read fetches the last vertex, so that edge (0, n-1) comes first
    assign rd_addr_full = (rd_cnt_reg == '0) ? (count_reg - CNT_W'(1))
                                             : (rd_cnt_reg - CNT_W'(1));
    assign rd_addr      = rd_addr_full[ADDR_W-1:0];

    // an edge is ready once the previous vertex is held
    assign edge_vld = rd_vld_reg & ~rd_first_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rd_cnt_next    = rd_cnt_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        rsp_load       = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        if (edge_stat.hit_vld)
        begin
            acc_next = ~acc_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (command)
                        pip_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        pip_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        pip_pkg::CMD_QUERY:
                        begin
                            acc_next    = 1'b0;
                            rd_cnt_next = '0;
                            // degenerate polygon answers outside at once
                            if (count_reg < CNT_W'(pip_pkg::MIN_VERTICES))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            // unused command code, dropped
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                rd_en       = 1'b1;
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                if (rd_cnt_reg == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the read and the edge pipeline to empty
                if (!rd_vld_reg && !edge_stat.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            acc_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_vld_reg    <= rd_en;
            rd_first_reg  <= rd_en & (rd_cnt_reg == '0);
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc && command == pip_pkg::CMD_QUERY)
        begin
            qx_reg <= cx;
            qy_reg <= cy;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= vx;
            prev_y_reg <= vy;
        end
        if (rsp_load)
        begin
            inside_reg  <= acc_reg;
            rsp_ovf_reg <= ovf_reg;
        end
    end

    pip_vstore #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CW)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({cy, cx}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // edge (i, j): vertex i just read, vertex j held from the read before
    pip_edge #(
        .COORD_WIDTH (CW)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (edge_vld),
        .ax     (vx),
        .ay     (vy),
        .bx     (prev_x_reg),
        .by     (prev_y_reg),
        .px     (qx_reg),
        .py     (qy_reg),
        .stat   (edge_stat)
    );

    assign rsp_valid       = rsp_valid_reg;
    assign inside_res      = inside_reg;
    assign vertex_overflow = rsp_ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pip_vstore.sv -----
// vertex store: single-port-write, single-port-read synchronous memory
// read data is registered; uses pip_pkg for the default sizes
`default_nettype none

module pip_vstore #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pip_edge.sv -----
// edge unit: two-stage pipeline for the half-open crossing test of one edge
// uses pip_pkg for the status struct
`default_nettype none

module pip_edge #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output pip_pkg::edge_stat_t           stat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] d_next;
    logic signed [DW-1:0] ex_next;
    logic signed [DW-1:0] dy_next;
    logic                 cross_next;
    logic                 dpos_next;

    logic                 s1_vld_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] ex_reg;
    logic signed [DW-1:0] dy_reg;
    logic                 cross1_reg;
    logic                 dpos1_reg;

    logic                 s2_vld_reg;
    logic signed [PW-1:0] lhs_reg;
    logic signed [PW-1:0] rhs_reg;
    logic                 cross2_reg;
    logic                 dpos2_reg;

    logic                 hit;

    // stage 1: differences and straddle test
    always_comb
    begin
        dx_next    = DW'(px) - DW'(ax);
        d_next     = DW'(by) - DW'(ay);
        ex_next    = DW'(bx) - DW'(ax);
        dy_next    = DW'(py) - DW'(ay);
        cross_next = (ay > py) != (by > py);
        dpos_next  = by > ay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        d_reg      <= d_next;
        ex_reg     <= ex_next;
        dy_reg     <= dy_next;
        cross1_reg <= cross_next;
        dpos1_reg  <= dpos_next;
        // stage 2: exact cross products
        lhs_reg    <= PW'(dx_reg) * PW'(d_reg);
        rhs_reg    <= PW'(ex_reg) * PW'(dy_reg);
        cross2_reg <= cross1_reg;
        dpos2_reg  <= dpos1_reg;
    end

    // sign of the edge height picks the direction of the compare
    assign hit = cross2_reg && (dpos2_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg));

    assign stat.busy    = s1_vld_reg | s2_vld_reg;
    assign stat.hit_vld = s2_vld_reg & hit;

endmodule

`default_nettype wire

// ----- rtl/core/pip_chk.sv -----
// port-level checker for the point-in-polygon block, bound to the top level
// uses pip_pkg for the command codes
`default_nettype none

module pip_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic [1:0]         command,
    input wire logic signed [31:0] coord_x,
    input wire logic signed [31:0] coord_y,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               inside_res,
    input wire logic               vertex_overflow
);

    logic req_acc;
    logic coord_seen;

    assign req_acc    = req_valid & req_ready;
    assign coord_seen = ^{coord_x, coord_y} | ~(^{coord_x, coord_y});

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(inside_res)
            && $stable(vertex_overflow))
        else $error("result changed while stalled");

    // the block is not ready in the cycle after a query is taken
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && command == pip_pkg::CMD_QUERY |=> !req_ready)
        else $error("request taken right after a query");

    // clear and append never stall the request side
    a_upd_free: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && coord_seen && (command == pip_pkg::CMD_CLEAR
            || command == pip_pkg::CMD_APPEND) |=> req_ready)
        else $error("block busy after clear or append");

    // a new result only comes out of a busy phase
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result without a query in flight");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (.*);

`default_nettype wire

// ----- tb/pip_crossing_checker.sv -----
`timescale 1ns / 1ps
// checker for the point-in-polygon block: watches the request and result channels
// keeps its own polygon, predicts every query answer and compares in order
// depends on pip_pkg for the command codes and the default sizes

module pip_crossing_checker #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic               inside_res,
    input  logic               vertex_overflow,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic in_poly;
        logic overflow;
    } answer_t;

    answer_t            expected_answers[$];
    logic signed [31:0] poly_x [MAX_VERTICES];
    logic signed [31:0] poly_y [MAX_VERTICES];
    int                 poly_len = 0;
    logic               appends_dropped = 1'b0;
    int                 fail_total = 0;
    int                 waiting = 0;

    assign fail_count = fail_total;
    assign pending    = waiting;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_total++;
    endtask

    // even-odd crossing count, half-open in y, exact cross multiplication
    function automatic logic even_odd_inside(input logic signed [31:0] px,
                                             input logic signed [31:0] py);
        logic               flag;
        logic               hit;
        int                 j;
        logic signed [31:0] ax, ay, bx, by;
        logic signed [33:0] dy_edge, dx_pt, dx_edge, dy_pt;
        logic signed [67:0] lhs, rhs;
        flag = 1'b0;
        if (poly_len < pip_pkg::MIN_VERTICES)
            return 1'b0;
        j = poly_len - 1;
        for (int i = 0; i < poly_len; i++)
        begin
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[j];
            by = poly_y[j];
            if ((ay > py) != (by > py))
            begin
                dy_edge = by - ay;
                dx_pt   = px - ax;
                dx_edge = bx - ax;
                dy_pt   = py - ay;
                lhs     = dx_pt * dy_edge;
                rhs     = dx_edge * dy_pt;
                hit     = (dy_edge > 0) ? (lhs < rhs) : (rhs < lhs);
                flag    = flag ^ hit;
            end
            j = i;
        end
        return flag;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        answer_t taken;
        if (!rst_n)
        begin
            poly_len        = 0;
            appends_dropped = 1'b0;
            expected_answers.delete();
            waiting <= 0;
        end
        else
        begin
            // results first: a request at this edge cannot be answered at it
            if (rsp_valid && rsp_ready)
            begin
                if (expected_answers.size() == 0)
                    flag_mismatch($sformatf("result with no query waiting, inside %b",
                                            inside_res));
                else
                begin
                    taken = expected_answers.pop_front();
                    if (inside_res !== taken.in_poly)
                        flag_mismatch($sformatf("inside_res %b, expected %b",
                                                inside_res, taken.in_poly));
                    if (vertex_overflow !== taken.overflow)
                        flag_mismatch($sformatf("vertex_overflow %b, expected %b",
                                                vertex_overflow, taken.overflow));
                end
            end
            if (req_valid && req_ready)
            begin
                case (command)
                    pip_pkg::CMD_CLEAR:
                    begin
                        poly_len        = 0;
                        appends_dropped = 1'b0;
                    end
                    pip_pkg::CMD_APPEND:
                    begin
                        if (poly_len < MAX_VERTICES)
                        begin
                            poly_x[poly_len] = coord_x;
                            poly_y[poly_len] = coord_y;
                            poly_len++;
                        end
                        else
                            appends_dropped = 1'b1;
                    end
                    pip_pkg::CMD_QUERY:
                    begin
                        taken.in_poly  = even_odd_inside(coord_x, coord_y);
                        taken.overflow = appends_dropped;
                        expected_answers = {expected_answers, taken};
                    end
                    default:
                    begin
                    end
                endcase
            end
            waiting <= expected_answers.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// top of the point-in-polygon testbench: clock, reset, request stimulus,
// result-side stalls and the verdict; checking lives in pip_crossing_checker
// depends on pip_pkg and the point_in_polygon_test block

module tb_top;

    localparam int MAX_VERTS   = pip_pkg::MAX_VERTICES_DEF;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = MAX_VERTS + 16;

    // the command code the block has no use for
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

    // coordinate spreads for a polygon and its queries
    typedef enum int { SPREAD_GRID, SPREAD_MID, SPREAD_FULL } spread_t;
    // where a query point is placed relative to the stored polygon
    typedef enum int { AT_RANDOM, AT_VERTEX, AT_EDGE_MID, ON_VERTEX_ROW, NEAR_VERTEX } spot_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [1:0]         command = pip_pkg::CMD_CLEAR;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic               inside_res;
    logic               vertex_overflow;

    int chk_fail_count;
    int chk_pending;
    int cycle_count = 0;
    int stall_left = 0;
    // when set, no new idle gaps or stalls start: back-to-back requests and results
    bit calm = 1'b0;

    always #1 clk = ~clk;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTS),
        .COORD_WIDTH (pip_pkg::COORD_WIDTH_DEF)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .inside_res     (inside_res),
        .vertex_overflow(vertex_overflow)
    );

    pip_crossing_checker #(
        .MAX_VERTICES(MAX_VERTS)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .inside_res     (inside_res),
        .vertex_overflow(vertex_overflow),
        .fail_count     (chk_fail_count),
        .pending        (chk_pending)
    );

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_length();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] rand_coord(input spread_t spread);
        int v;
        case (spread)
            // whole units on a small grid, so points land on edges and vertices
            SPREAD_GRID:
            begin
                v = $urandom_range(0, 16);
                return (v - 8) * 256;
            end
            SPREAD_MID:
            begin
                v = $urandom_range(0, 200000);
                return v - 100000;
            end
            default:
                return $urandom;
        endcase
    endfunction

    // result side: ready drops for random stretches; no new stretch starts while calm
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= gap_length();
        end
        else
            rsp_ready <= 1'b1;
    end

    // one request: optional idle gap, then hold valid until accepted;
    // returns at the accepting edge with valid still high
    task automatic push_request(input logic [1:0] cmd, input logic signed [31:0] x,
                                input logic signed [31:0] y);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        coord_x   <= x;
        coord_y   <= y;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // stop sending and wait until every query has been answered
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
    endtask

    initial
    begin
        int                 sent;
        int                 seq_no;
        int                 nv;
        int                 nq;
        int                 roll;
        int                 vi;
        spread_t            spread;
        spot_t              spot;
        logic signed [31:0] vx [80];
        logic signed [31:0] vy [80];
        logic signed [32:0] sum_x, sum_y;
        logic signed [31:0] qx, qy;

        sent   = 0;
        seq_no = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // query on an empty store, then with only two vertices
        push_request(pip_pkg::CMD_QUERY, 32'sd100, 32'sd100);
        push_request(pip_pkg::CMD_APPEND, 32'sd0, 32'sd0);
        push_request(pip_pkg::CMD_APPEND, 32'sd2560, 32'sd0);
        push_request(pip_pkg::CMD_QUERY, 32'sd100, 32'sd10);
        // unused command code must leave everything alone
        push_request(CMD_SPARE, COORD_MAX, COORD_MIN);
        // complete a 10 x 10 square
        push_request(pip_pkg::CMD_APPEND, 32'sd2560, 32'sd2560);
        push_request(pip_pkg::CMD_APPEND, 32'sd0, 32'sd2560);
        // center, left and right edges, a corner, top and bottom edges, outside
        push_request(pip_pkg::CMD_QUERY, 32'sd1280, 32'sd1280);
        push_request(pip_pkg::CMD_QUERY, 32'sd0, 32'sd1280);
        push_request(pip_pkg::CMD_QUERY, 32'sd2560, 32'sd1280);
        push_request(pip_pkg::CMD_QUERY, 32'sd0, 32'sd0);
        push_request(pip_pkg::CMD_QUERY, 32'sd1280, 32'sd2560);
        push_request(pip_pkg::CMD_QUERY, 32'sd1280, 32'sd0);
        push_request(pip_pkg::CMD_QUERY, 32'sd3000, 32'sd1280);
        // triangle spanning the whole coordinate range
        push_request(pip_pkg::CMD_CLEAR, COORD_MAX, COORD_MAX);
        push_request(pip_pkg::CMD_APPEND, COORD_MIN, COORD_MIN);
        push_request(pip_pkg::CMD_APPEND, COORD_MAX, COORD_MIN);
        push_request(pip_pkg::CMD_APPEND, 32'sd0, COORD_MAX);
        push_request(pip_pkg::CMD_QUERY, 32'sd0, 32'sd0);
        push_request(pip_pkg::CMD_QUERY, COORD_MAX, COORD_MAX);
        push_request(pip_pkg::CMD_QUERY, COORD_MIN, 32'sd0);
        push_request(pip_pkg::CMD_QUERY, -32'sd1, COORD_MIN);
        sent = 21;

        // random polygons, each followed by a burst of queries around it
        while (sent < ITEM_TARGET)
        begin
            seq_no++;
            calm = ($urandom_range(0, 5) == 0);
            // hold the sender off until the block has answered everything
            if (seq_no % 25 == 12)
                drain_results();
            spread = spread_t'($urandom_range(0, 2));
            // now and then keep appending onto the previous polygon
            if ($urandom_range(0, 9) != 0)
            begin
                push_request(pip_pkg::CMD_CLEAR, $urandom, $urandom);
                sent++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
                nv = $urandom_range(60, 72);
            else if (roll < 15)
                nv = $urandom_range(0, 2);
            else
                nv = $urandom_range(3, 12);
            for (int k = 0; k < nv; k++)
            begin
                vx[k] = rand_coord(spread);
                vy[k] = rand_coord(spread);
                push_request(pip_pkg::CMD_APPEND, vx[k], vy[k]);
                sent++;
                if ($urandom_range(0, 39) == 0)
                    push_request(CMD_SPARE, $urandom, $urandom);
            end
            nq = $urandom_range(2, 8);
            for (int k = 0; k < nq; k++)
            begin
                vi   = (nv > 0) ? $urandom_range(0, nv - 1) : 0;
                spot = (nv > 0) ? spot_t'($urandom_range(0, 4)) : AT_RANDOM;
                case (spot)
                    AT_VERTEX:
                    begin
                        qx = vx[vi];
                        qy = vy[vi];
                    end
                    AT_EDGE_MID:
                    begin
                        sum_x = vx[vi] + vx[(vi + 1) % nv];
                        sum_y = vy[vi] + vy[(vi + 1) % nv];
                        qx    = sum_x[32:1];
                        qy    = sum_y[32:1];
                    end
                    // horizontal ray passing exactly through a vertex
                    ON_VERTEX_ROW:
                    begin
                        qx = rand_coord(spread);
                        qy = vy[vi];
                    end
                    NEAR_VERTEX:
                    begin
                        qx = vx[vi] + (int'($urandom_range(0, 2)) - 1);
                        qy = vy[vi] + (int'($urandom_range(0, 2)) - 1);
                    end
                    default:
                    begin
                        qx = rand_coord(spread);
                        qy = rand_coord(spread);
                    end
                endcase
                push_request(pip_pkg::CMD_QUERY, qx, qy);
                sent++;
            end
        end

        calm = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
